// ===== rtl/icw_pkg.sv =====
// ============================================================================
// icw_pkg: shared definitions for the inspect/convert window block
// Constants, register codes and the configuration record used by the RTL.
// ============================================================================
package icw_pkg;

    localparam int DELIM_MAX_DEF = 8;
    localparam int SET_MAX_DEF   = 8;
    localparam int LEN_MAX_DEF   = 65535;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_REG_W = 4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FROM_CHARS    = 3'd0,
        REG_FROM_COUNT    = 3'd1,
        REG_TO_CHARS      = 3'd2,
        REG_BEFORE_DELIM  = 3'd3,
        REG_BEFORE_LEN    = 3'd4,
        REG_AFTER_DELIM   = 3'd5,
        REG_AFTER_LEN     = 3'd6,
        REG_AFTER_ENABLED = 3'd7
    } icw_reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]     from_chars;
        logic [LEN_REG_W-1:0] from_count;
        logic [CFG_W-1:0]     to_chars;
        logic [CFG_W-1:0]     before_delim;
        logic [LEN_REG_W-1:0] before_len;
        logic [CFG_W-1:0]     after_delim;
        logic [LEN_REG_W-1:0] after_len;
        logic                 after_enabled;
    } icw_cfg_t;

    // One result word as it sits in the output buffer.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } icw_word_t;

endpackage

// ===== rtl/icw_if.sv =====
// ============================================================================
// icw_if: stream channels of the inspect/convert window block
// Input channel carries field bytes, output channel carries result bytes.
// ============================================================================
interface icw_in_if;
    logic                      valid;
    logic                      ready;
    logic [icw_pkg::BYTE_W-1:0] in_byte;
    logic                      in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface icw_out_if;
    logic                      valid;
    logic                      ready;
    logic [icw_pkg::BYTE_W-1:0] out_byte;
    logic                      out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/icw_cfg.sv =====
// ============================================================================
// icw_cfg: configuration register file
// Eight write-only registers, written through a plain index/data port.
// ============================================================================
module icw_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [icw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [icw_pkg::CFG_W-1:0]       cfg_wdata,
    output icw_pkg::icw_cfg_t               cfg
);

    icw_pkg::icw_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (icw_pkg::icw_reg_idx_t'(cfg_index))
                icw_pkg::REG_FROM_CHARS:    cfg_reg.from_chars    <= cfg_wdata;
                icw_pkg::REG_FROM_COUNT:
                    cfg_reg.from_count <= cfg_wdata[icw_pkg::LEN_REG_W-1:0];
                icw_pkg::REG_TO_CHARS:      cfg_reg.to_chars      <= cfg_wdata;
                icw_pkg::REG_BEFORE_DELIM:  cfg_reg.before_delim  <= cfg_wdata;
                icw_pkg::REG_BEFORE_LEN:
                    cfg_reg.before_len <= cfg_wdata[icw_pkg::LEN_REG_W-1:0];
                icw_pkg::REG_AFTER_DELIM:   cfg_reg.after_delim   <= cfg_wdata;
                icw_pkg::REG_AFTER_LEN:
                    cfg_reg.after_len <= cfg_wdata[icw_pkg::LEN_REG_W-1:0];
                icw_pkg::REG_AFTER_ENABLED: cfg_reg.after_enabled <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/icw_tail_match.sv =====
// ============================================================================
// icw_tail_match: delimiter compare against the newest bytes
// All delimiter lengths are compared in parallel; the length picks one.
// ============================================================================
module icw_tail_match #(
    parameter int DELIM_MAX = icw_pkg::DELIM_MAX_DEF
) (
    input  logic [DELIM_MAX-1:0][icw_pkg::BYTE_W-1:0] recent,
    input  logic [icw_pkg::CFG_W-1:0]                 delim,
    input  logic [icw_pkg::LEN_REG_W-1:0]             len,
    output logic                                      match
);

    localparam int CAP   = (DELIM_MAX < 8) ? DELIM_MAX : 8;
    localparam int LSEL_W = (CAP > 1) ? $clog2(CAP + 1) : 1;

    logic [CAP:0] hit;

    // hit[L] is set when the newest L bytes equal delimiter bytes 0..L-1,
    // with delimiter byte 0 being the oldest of them.
    always_comb
    begin
        hit = '0;
        for (int l = 1; l <= CAP; l++)
        begin
            hit[l] = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (recent[l-1-j] != delim[icw_pkg::BYTE_W*j +: icw_pkg::BYTE_W])
                begin
                    hit[l] = 1'b0;
                end
            end
        end
    end

    assign match = (len != '0) && hit[len[LSEL_W-1:0]];

endmodule

// ===== rtl/icw_xlate.sv =====
// ============================================================================
// icw_xlate: character translation lookup
// First matching entry of the source set selects the replacement byte.
// ============================================================================
module icw_xlate #(
    parameter int SET_MAX = icw_pkg::SET_MAX_DEF
) (
    input  icw_pkg::icw_cfg_t             cfg,
    input  logic [icw_pkg::BYTE_W-1:0]    data,
    input  logic                          in_window,
    output logic [icw_pkg::BYTE_W-1:0]    result
);

    logic [icw_pkg::LEN_REG_W-1:0] n_eff;

    assign n_eff = (cfg.from_count > icw_pkg::LEN_REG_W'(SET_MAX)) ?
                   icw_pkg::LEN_REG_W'(SET_MAX) : cfg.from_count;

    // Scanning from the top down leaves the lowest matching entry in place.
    always_comb
    begin
        result = data;
        if (in_window)
        begin
            for (int k = SET_MAX - 1; k >= 0; k--)
            begin
                if ((icw_pkg::LEN_REG_W'(k) < n_eff) &&
                    (cfg.from_chars[icw_pkg::BYTE_W*k +: icw_pkg::BYTE_W] == data))
                begin
                    result = cfg.to_chars[icw_pkg::BYTE_W*k +: icw_pkg::BYTE_W];
                end
            end
        end
    end

endmodule

// ===== rtl/icw_out_buf.sv =====
// ============================================================================
// icw_out_buf: two-word output buffer
// Output register plus skid register; space is a registered flag.
// ============================================================================
module icw_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  icw_pkg::icw_word_t push_word,
    output logic               space,
    icw_out_if.source          result
);

    icw_pkg::icw_word_t main_reg, main_next;
    icw_pkg::icw_word_t skid_reg, skid_next;
    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               pop;

    assign pop = main_valid_reg && result.ready;

    // A push only arrives while the skid register is empty.
    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_next       = push_word;
                skid_valid_next = push;
            end
            else
            begin
                main_next       = push_word;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_word;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign space           = !skid_valid_reg;
    assign result.valid    = main_valid_reg;
    assign result.out_byte = main_reg.data;
    assign result.out_last = main_reg.last;

endmodule

// ===== rtl/inspect_convert_window.sv =====
// ============================================================================
// inspect_convert_window: windowed character conversion over a text field
// Translates the bytes of a field that lie between the AFTER and BEFORE
// delimiters, with a lag of DELIM_MAX-1 words and a flush on the last word.
// ============================================================================
//
//  Channel   Direction  Payload               Handshake
//  --------  ---------  --------------------  ------------------------------
//  text      in         in_byte[8], in_last   valid/ready, taken when both high
//  result    out        out_byte[8], out_last valid/ready, taken when both high
//  cfg_*     in         cfg_index, cfg_wdata  write when cfg_we is high
//
// Every input word is handled in the cycle it is taken: it enters the history
// register, both delimiters are compared against the newest bytes, and once
// DELIM_MAX words are held the oldest one is translated and written to the
// output buffer. One word per cycle is sustained while a field streams and
// the output buffer has space. A word marked last starts a flush: the held
// words (up to DELIM_MAX) leave one per cycle while the buffer has space,
// through the same translation unit, and the input is stalled until the
// flush is done. The output buffer holds two words, so a stalled result side
// stops input only once both are full. Reset clears all field state at once.
// ============================================================================
module inspect_convert_window #(
    parameter int DELIM_MAX = icw_pkg::DELIM_MAX_DEF,
    parameter int SET_MAX   = icw_pkg::SET_MAX_DEF,
    parameter int LEN_MAX   = icw_pkg::LEN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    icw_in_if.sink                          text,
    icw_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [icw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [icw_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int POS_W = $clog2(LEN_MAX + 1);
    localparam int WS_W  = POS_W + 1;
    localparam int HC_W  = $clog2(DELIM_MAX + 1);
    localparam int AGE_W = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
    localparam int CAP   = (DELIM_MAX < 8) ? DELIM_MAX : 8;
    localparam int LW    = icw_pkg::LEN_REG_W;
    localparam int BW    = icw_pkg::BYTE_W;

    icw_pkg::icw_cfg_t cfg;

    // Field state. pos_reg is the position of the next word; during a flush
    // it holds the position of the last word instead.
    logic [DELIM_MAX-1:0][BW-1:0] recent_reg, recent_next;
    logic [HC_W-1:0]              held_reg, held_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         bfound_reg, bfound_next;
    logic [POS_W-1:0]             bstart_reg, bstart_next;
    logic                         afound_reg, afound_next;
    logic [WS_W-1:0]              wstart_reg, wstart_next;
    logic                         flushing_reg, flushing_next;

    logic                         accept;
    logic                         buf_space;
    logic [DELIM_MAX-1:0][BW-1:0] shifted;
    logic [LW-1:0]                alen, blen;
    logic                         a_hit, b_hit, a_set, b_set;
    logic [WS_W-1:0]              p1;
    logic                         afound_upd, bfound_upd;
    logic [WS_W-1:0]              wstart_upd;
    logic [POS_W-1:0]             bstart_upd;
    logic [HC_W-1:0]              held_inc;
    logic                         emit_ord, flush_emit;

    logic [AGE_W-1:0]             e_age;
    logic [BW-1:0]                e_data, e_result;
    logic                         e_last;
    logic [POS_W-1:0]             e_pos;
    logic                         e_af, e_bf;
    logic [WS_W-1:0]              e_ws;
    logic [POS_W-1:0]             e_bs;
    logic                         in_window;
    icw_pkg::icw_word_t           push_word;

    icw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The input is held off during a flush and while the skid slot is busy.
    assign text.ready = !flushing_reg && buf_space;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        shifted[0] = text.in_byte;
        for (int i = 1; i < DELIM_MAX; i++)
        begin
            shifted[i] = recent_reg[i-1];
        end
    end

    // Delimiter lengths beyond what the history can hold are clamped.
    assign alen = (cfg.after_len  > LW'(CAP)) ? LW'(CAP) : cfg.after_len;
    assign blen = (cfg.before_len > LW'(CAP)) ? LW'(CAP) : cfg.before_len;

    icw_tail_match #(.DELIM_MAX(DELIM_MAX)) u_after_match (
        .recent (shifted),
        .delim  (cfg.after_delim),
        .len    (alen),
        .match  (a_hit)
    );

    icw_tail_match #(.DELIM_MAX(DELIM_MAX)) u_before_match (
        .recent (shifted),
        .delim  (cfg.before_delim),
        .len    (blen),
        .match  (b_hit)
    );

    // Only the first occurrence of each delimiter counts, and a delimiter
    // longer than the field so far cannot match.
    assign p1    = {1'b0, pos_reg} + WS_W'(1);
    assign a_set = cfg.after_enabled && !afound_reg && (p1 >= WS_W'(alen)) && a_hit;
    assign b_set = !bfound_reg && (p1 >= WS_W'(blen)) && b_hit;

    assign afound_upd = afound_reg || a_set;
    assign wstart_upd = a_set ? p1 : wstart_reg;
    assign bfound_upd = bfound_reg || b_set;
    assign bstart_upd = b_set ? POS_W'(p1 - WS_W'(blen)) : bstart_reg;

    assign held_inc   = (held_reg < HC_W'(DELIM_MAX)) ? held_reg + HC_W'(1) : held_reg;
    assign emit_ord   = accept && !text.in_last && (held_inc == HC_W'(DELIM_MAX));
    assign flush_emit = flushing_reg && buf_space;

    // Emission source: the oldest word of a streaming field, judged against
    // the window as updated by the word just taken, or a held word during a
    // flush, judged against the stored window.
    always_comb
    begin
        if (flushing_reg)
        begin
            e_age  = AGE_W'(held_reg - HC_W'(1));
            e_data = recent_reg[e_age];
            e_last = (held_reg == HC_W'(1));
            e_af   = afound_reg;
            e_ws   = wstart_reg;
            e_bf   = bfound_reg;
            e_bs   = bstart_reg;
        end
        else
        begin
            e_age  = AGE_W'(DELIM_MAX - 1);
            e_data = shifted[DELIM_MAX-1];
            e_last = 1'b0;
            e_af   = afound_upd;
            e_ws   = wstart_upd;
            e_bf   = bfound_upd;
            e_bs   = bstart_upd;
        end
    end

    // A held word's position is the newest position minus its age, floored
    // at zero; this stays right after the position counter has saturated.
    assign e_pos = (pos_reg >= POS_W'(e_age)) ? pos_reg - POS_W'(e_age) : '0;

    assign in_window = !(cfg.after_enabled && (!e_af || ({1'b0, e_pos} < e_ws))) &&
                       !(e_bf && (e_pos >= e_bs));

    icw_xlate #(.SET_MAX(SET_MAX)) u_xlate (
        .cfg       (cfg),
        .data      (e_data),
        .in_window (in_window),
        .result    (e_result)
    );

    assign push_word.data = e_result;
    assign push_word.last = e_last;

    icw_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit_ord || flush_emit),
        .push_word (push_word),
        .space     (buf_space),
        .result    (result)
    );

    always_comb
    begin
        recent_next   = recent_reg;
        held_next     = held_reg;
        pos_next      = pos_reg;
        bfound_next   = bfound_reg;
        bstart_next   = bstart_reg;
        afound_next   = afound_reg;
        wstart_next   = wstart_reg;
        flushing_next = flushing_reg;

        if (accept)
        begin
            recent_next = shifted;
            afound_next = afound_upd;
            wstart_next = wstart_upd;
            bfound_next = bfound_upd;
            bstart_next = bstart_upd;
            if (text.in_last)
            begin
                // Position stays on the last word for the flush.
                held_next     = held_inc;
                flushing_next = 1'b1;
            end
            else
            begin
                pos_next  = (pos_reg < POS_W'(LEN_MAX)) ? pos_reg + POS_W'(1) : pos_reg;
                held_next = emit_ord ? held_inc - HC_W'(1) : held_inc;
            end
        end
        else if (flush_emit)
        begin
            held_next = held_reg - HC_W'(1);
            if (held_reg == HC_W'(1))
            begin
                flushing_next = 1'b0;
                pos_next      = '0;
                bfound_next   = 1'b0;
                bstart_next   = '0;
                afound_next   = 1'b0;
                wstart_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg   <= '0;
            held_reg     <= '0;
            pos_reg      <= '0;
            bfound_reg   <= 1'b0;
            bstart_reg   <= '0;
            afound_reg   <= 1'b0;
            wstart_reg   <= '0;
            flushing_reg <= 1'b0;
        end
        else
        begin
            recent_reg   <= recent_next;
            held_reg     <= held_next;
            pos_reg      <= pos_next;
            bfound_reg   <= bfound_next;
            bstart_reg   <= bstart_next;
            afound_reg   <= afound_next;
            wstart_reg   <= wstart_next;
            flushing_reg <= flushing_next;
        end
    end

endmodule

// ===== rtl/icw_checker.sv =====
// ============================================================================
// icw_checker: port-level checks for the inspect/convert window block
// Counts words in flight and open fields and checks them over time.
// ============================================================================
module icw_checker #(
    parameter int DELIM_MAX = icw_pkg::DELIM_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       in_last,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [icw_pkg::BYTE_W-1:0] out_byte,
    input  logic                       out_last
);

    localparam int PEND_W = $clog2(DELIM_MAX + 3) + 1;

    logic              in_take, out_take;
    logic [PEND_W-1:0] pending_reg;
    logic [1:0]        open_reg;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            open_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + PEND_W'(in_take) - PEND_W'(out_take);
            open_reg    <= open_reg + 2'(in_take && in_last) - 2'(out_take && out_last);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("result word changed while stalled");

    a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && in_last |=> !in_ready)
        else $error("input taken right after a last word");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result word shown with no input word outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(DELIM_MAX + 1))
        else $error("more words held than the history and buffer allow");

    a_last_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && out_last |-> open_reg != 2'd0)
        else $error("last result word without a finished input field");

endmodule

bind inspect_convert_window icw_checker #(.DELIM_MAX(DELIM_MAX)) u_icw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .in_last   (text.in_last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_byte  (result.out_byte),
    .out_last  (result.out_last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for inspect_convert_window
// Streams text fields through the block, predicts every result word from a
// model of the AFTER/BEFORE window and the from/to translation set, and
// checks the result channel word by word.
// ============================================================================
module testbench;

    localparam int DM        = icw_pkg::DELIM_MAX_DEF;
    localparam int SM        = icw_pkg::SET_MAX_DEF;
    localparam int LM        = icw_pkg::LEN_MAX_DEF;
    localparam int DCAP      = (DM < 8) ? DM : 8;
    // Leave a margin after a flush before any register write.
    localparam int SETTLE    = 2 * DM + 8;
    localparam int TIMEOUT   = 200_000;
    localparam int RAND_PHASES = 8;

    typedef struct {
        logic [7:0] b;
        logic       last;
    } text_word_t;

    logic clk;
    logic rst_n;
    logic                          cfg_we;
    logic [icw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [icw_pkg::CFG_W-1:0]     cfg_wdata;

    icw_in_if  text_ch ();
    icw_out_if result_ch ();

    inspect_convert_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    text_word_t          text_q [$];   // words waiting to be offered on the text channel
    icw_pkg::icw_word_t  xlat_q [$];   // predicted result words, oldest first
    icw_pkg::icw_cfg_t   shadow_cfg;   // copy of the block's registers
    logic [7:0]  alphabet [4];    // small character set that makes delimiters likely
    int          err_count;
    int          cycle_count;

    // Window model state: recent bytes newest first, bytes held back, the
    // position of the next byte and where the window opens and closes.
    logic [7:0]  hist [DM];
    int          held;
    int          fpos;
    bit          bfound;
    int          bstart;
    bit          afound;
    int          wstart;

    // Sender and receiver pacing.
    int          gap_left;
    int          burst_left;
    int          stall_mode;
    int          mode_left;
    text_word_t  nxt;

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT)
        begin
            $display("inspect_convert_window verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int clamp_len(input logic [3:0] v);
        return (v > DCAP) ? DCAP : int'(v);
    endfunction

    // True when the newest len bytes spell the delimiter, delimiter byte 0 oldest.
    function automatic bit tail_is(input logic [63:0] d, input int len);
        for (int j = 0; j < len; j++)
        begin
            if (hist[len - 1 - j] !== d[8*j +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Translation of one byte at a given field position. Outside the window
    // the byte passes as it is; inside it the first matching set entry wins.
    function automatic logic [7:0] map_char(input logic [7:0] b, input int pos);
        int n;
        n = (shadow_cfg.from_count > SM) ? SM : int'(shadow_cfg.from_count);
        if (shadow_cfg.after_enabled && (!afound || pos < wstart))
            return b;
        if (bfound && pos >= bstart)
            return b;
        for (int k = 0; k < n; k++)
        begin
            if (shadow_cfg.from_chars[8*k +: 8] == b)
                return shadow_cfg.to_chars[8*k +: 8];
        end
        return b;
    endfunction

    // Takes one accepted text word into the model and queues the result
    // words that it releases: the oldest held byte once the lag is full, or
    // every held byte when the word closes the field.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int p;
        int blen;
        int alen;
        int age;
        int pos;
        icw_pkg::icw_word_t w;
        p    = fpos;
        blen = clamp_len(shadow_cfg.before_len);
        alen = clamp_len(shadow_cfg.after_len);
        for (int i = DM - 1; i > 0; i--)
            hist[i] = hist[i - 1];
        hist[0] = b;
        if (held < DM)
            held++;
        fpos = (p < LM) ? p + 1 : LM;

        if (shadow_cfg.after_enabled && !afound && alen > 0 && p + 1 >= alen &&
            tail_is(shadow_cfg.after_delim, alen))
        begin
            afound = 1'b1;
            wstart = (p + 1) & 32'h1FFFF;
        end
        if (!bfound && blen > 0 && p + 1 >= blen && tail_is(shadow_cfg.before_delim, blen))
        begin
            bfound = 1'b1;
            bstart = (p + 1 - blen) & 32'hFFFF;
        end

        if (last)
        begin
            for (int a = held; a > 0; a--)
            begin
                age    = a - 1;
                pos    = (p >= age) ? p - age : 0;
                w.data = map_char(hist[age], pos);
                w.last = (age == 0);
                xlat_q.push_back(w);
            end
            held   = 0;
            fpos   = 0;
            bfound = 1'b0;
            bstart = 0;
            afound = 1'b0;
            wstart = 0;
        end
        else if (held > DM - 1)
        begin
            age    = held - 1;
            pos    = (p >= age) ? p - age : 0;
            w.data = map_char(hist[age], pos);
            w.last = 1'b0;
            xlat_q.push_back(w);
            held--;
        end
    endtask

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: text words go into the model first, so that a result word
    // released by the same edge already has its expectation queued.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
                absorb_byte(text_ch.in_byte, text_ch.in_last);
            if (result_ch.valid && result_ch.ready)
            begin
                if (xlat_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected result word byte=%h last=%b",
                                         result_ch.out_byte, result_ch.out_last));
                end
                else
                begin
                    icw_pkg::icw_word_t want;
                    want = xlat_q.pop_front();
                    if (result_ch.out_byte !== want.data)
                        flag_error($sformatf("out_byte mismatch: expected %h, got %h",
                                             want.data, result_ch.out_byte));
                    if (result_ch.out_last !== want.last)
                        flag_error($sformatf("out_last mismatch: expected %b, got %b",
                                             want.last, result_ch.out_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A word
    // stays on the channel until it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!text_ch.valid || text_ch.ready)
            begin
                if (gap_left > 0 || text_q.size() == 0)
                begin
                    text_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    nxt = text_q.pop_front();
                    text_ch.valid   <= 1'b1;
                    text_ch.in_byte <= nxt.b;
                    text_ch.in_last <= nxt.last;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // Receiver: ready follows a randomly chosen pattern, picked anew when its run
    // ends: always ready, coin toss, mostly stalled, or alternating.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= ~result_ch.ready;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Writes all eight registers, one per cycle, while the block is idle.
    task automatic write_cfg(input icw_pkg::icw_cfg_t c);
        icw_pkg::icw_reg_idx_t     ri;
        logic [icw_pkg::CFG_W-1:0] val;
        for (int i = 0; i < 8; i++)
        begin
            ri = icw_pkg::icw_reg_idx_t'(i);
            case (ri)
                icw_pkg::REG_FROM_CHARS:   val = c.from_chars;
                icw_pkg::REG_FROM_COUNT:   val = icw_pkg::CFG_W'(c.from_count);
                icw_pkg::REG_TO_CHARS:     val = c.to_chars;
                icw_pkg::REG_BEFORE_DELIM: val = c.before_delim;
                icw_pkg::REG_BEFORE_LEN:   val = icw_pkg::CFG_W'(c.before_len);
                icw_pkg::REG_AFTER_DELIM:  val = c.after_delim;
                icw_pkg::REG_AFTER_LEN:    val = icw_pkg::CFG_W'(c.after_len);
                default:                   val = icw_pkg::CFG_W'(c.after_enabled);
            endcase
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= ri;
            cfg_wdata <= val;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cfg = c;
    endtask

    // Waits until every word has been offered and taken and every predicted
    // result word has arrived, then waits out the settle margin.
    task automatic wait_idle(input int settle);
        do
            @(posedge clk);
        while (text_q.size() != 0 || text_ch.valid || xlat_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 3) != 0)
            return alphabet[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] pick_delim();
        logic [63:0] d;
        for (int j = 0; j < 8; j++)
            d[8*j +: 8] = ($urandom_range(0, 4) != 0) ? alphabet[$urandom_range(0, 3)]
                                                      : 8'($urandom_range(0, 255));
        return d;
    endfunction

    function automatic logic [3:0] pick_len();
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(1, 4));
    endfunction

    // Queues a field of len bytes. A copy of the AFTER and the BEFORE
    // delimiter is planted at a random place when asked; close marks the
    // final byte as last, otherwise the field goes on in a later call.
    task automatic add_field(input int len, input bit with_after, input bit with_before,
                             input bit close);
        logic [7:0] fb [$];
        int alen;
        int blen;
        int at;
        text_word_t w;
        for (int i = 0; i < len; i++)
            fb.push_back(pick_char());
        alen = clamp_len(shadow_cfg.after_len);
        blen = clamp_len(shadow_cfg.before_len);
        if (with_after && alen > 0 && alen <= len)
        begin
            at = $urandom_range(0, len - alen);
            for (int j = 0; j < alen; j++)
                fb[at + j] = shadow_cfg.after_delim[8*j +: 8];
        end
        if (with_before && blen > 0 && blen <= len)
        begin
            at = $urandom_range(0, len - blen);
            for (int j = 0; j < blen; j++)
                fb[at + j] = shadow_cfg.before_delim[8*j +: 8];
        end
        for (int i = 0; i < len; i++)
        begin
            w.b    = fb[i];
            w.last = close && (i == len - 1);
            text_q.push_back(w);
        end
    endtask

    // Queues an exact string of bytes, byte 0 first.
    task automatic add_bytes(input logic [7:0] s [$], input bit close);
        text_word_t w;
        for (int i = 0; i < s.size(); i++)
        begin
            w.b    = s[i];
            w.last = close && (i == s.size() - 1);
            text_q.push_back(w);
        end
    endtask

    function automatic icw_pkg::icw_cfg_t random_cfg();
        icw_pkg::icw_cfg_t c;
        for (int j = 0; j < 4; j++)
            alphabet[j] = 8'($urandom_range(0, 255));
        for (int k = 0; k < 8; k++)
            c.from_chars[8*k +: 8] = ($urandom_range(0, 2) != 0) ? alphabet[$urandom_range(0, 3)]
                                                                 : 8'($urandom_range(0, 255));
        c.to_chars      = {$urandom, $urandom};
        c.from_count    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(1, 8));
        c.before_delim  = pick_delim();
        c.before_len    = pick_len();
        c.after_delim   = pick_delim();
        c.after_len     = pick_len();
        c.after_enabled = ($urandom_range(0, 1) == 1);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        icw_pkg::icw_cfg_t c;
        int       count;
        int       len;
        logic [7:0] s [$];

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        text_ch.valid     = 1'b0;
        text_ch.in_byte   = '0;
        text_ch.in_last   = 1'b0;
        result_ch.ready   = 1'b0;
        err_count         = 0;
        cycle_count       = 0;
        gap_left          = 0;
        burst_left        = 0;
        stall_mode        = 0;
        mode_left         = 0;
        held              = 0;
        fpos              = 0;
        bfound            = 1'b0;
        bstart            = 0;
        afound            = 1'b0;
        wstart            = 0;
        for (int i = 0; i < DM; i++)
            hist[i] = '0;
        shadow_cfg = '0;
        alphabet   = '{8'h61, 8'h62, 8'h63, 8'h64};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Registers at their reset values first: an empty
        // from set, so every byte passes through, including a one-byte field.
        s = '{8'h00, 8'hFF};
        add_bytes(s, 1'b1);
        s = '{8'h5A};
        add_bytes(s, 1'b1);
        wait_idle(SETTLE);

        // Window between "<" and "END". The from set repeats 'a' so the
        // first entry must win, and from_count beyond the set size saturates.
        c.from_chars    = {"g", "f", "e", "d", "c", "a", "b", "a"};
        c.to_chars      = {"7", "6", "5", "4", "3", "X", "B", "A"};
        c.from_count    = 4'd15;
        c.before_delim  = 64'(24'h444E45);           // "END", byte 0 first
        c.before_len    = 4'd3;
        c.after_delim   = 64'(8'h3C);                // "<"
        c.after_len     = 4'd1;
        c.after_enabled = 1'b1;
        write_cfg(c);
        s = '{"a", "<", "a", "b", "E", "N", "D", "a", "c"};
        add_bytes(s, 1'b1);
        // No AFTER delimiter in this field, so nothing is translated.
        s = '{"E", "N", "a"};
        add_bytes(s, 1'b1);
        wait_idle(SETTLE);

        // AFTER clause present but its delimiter empty: no translation, and
        // an empty BEFORE delimiter sets no upper limit.
        c.after_len  = 4'd0;
        c.before_len = 4'd0;
        c.from_count = 4'd8;
        write_cfg(c);
        s = '{"a", "b", "c"};
        add_bytes(s, 1'b1);
        wait_idle(SETTLE);

        // All registers but to_chars at their top values; both delimiters are longer
        // than the field, so neither can match.
        c.from_chars    = '1;
        c.to_chars      = '0;
        c.from_count    = 4'hF;
        c.before_delim  = '1;
        c.before_len    = 4'hF;
        c.after_delim   = '1;
        c.after_len     = 4'hF;
        c.after_enabled = 1'b1;
        write_cfg(c);
        s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_bytes(s, 1'b1);
        wait_idle(SETTLE);

        // Random phases: a fresh register setting each time, fields built
        // from a small character set with delimiters planted in most.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            c = random_cfg();
            if (ph == 1)
            begin
                // Full-length delimiters and a full from set.
                c.before_len    = 4'd8;
                c.after_len     = 4'd8;
                c.from_count    = 4'd8;
                c.after_enabled = 1'b1;
            end
            write_cfg(c);
            count = 0;
            if (ph == 2)
            begin
                // Stop in the middle of a field and let every released word
                // drain before the field goes on.
                add_field(12, 1'b1, 1'b0, 1'b0);
                wait_idle(0);
                count = 12;
            end
            while (count < 56)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
                add_field(len, $urandom_range(0, 4) != 0, $urandom_range(0, 2) != 0, 1'b1);
                count += len;
            end
            wait_idle(SETTLE);
        end

        if (err_count == 0 && xlat_q.size() == 0)
            $display("inspect_convert_window verification clean");
        else
            $display("inspect_convert_window verification failed");
        $finish;
    end

endmodule
